// ----- hdl/cals_pkg.sv -----
// shared types, constants and tables for the cellular automaton lifetime search
package cals_pkg;

	// field widths
	localparam int RULE_W  = 43;
	localparam int LIFE_W  = 5;
	localparam int THR_W   = 5;
	localparam int TRIT_W  = 2;

	// torus geometry: side 3, one dimension, neighbourhood of 3 cells
	localparam int NUM_CELLS   = 3;
	localparam int NUM_CONFIGS = 27;
	localparam int CONF_W      = 5;

	// rule digit extraction: divide by 27 per pass, 8 dividend bits per cycle
	localparam int CHUNK_W    = 8;
	localparam int NUM_CHUNKS = 6;
	localparam int WORK_W     = CHUNK_W * NUM_CHUNKS;
	localparam int NUM_PASSES = 9;
	localparam int PASS_W     = 4;
	localparam int CHUNK_CW   = 3;
	localparam int REM_W      = 5;
	localparam int DIVISOR    = 27;

	// digit memory: one row holds three digits, row index 0..8
	localparam int ROW_W      = 3 * TRIT_W;
	localparam int ROW_AW     = 4;
	localparam int CELL_CW    = 2;

	// base-3 digits of 0..26, packed as {d2, d1, d0}
	localparam logic [ROW_W-1:0] TRIT_LUT [NUM_CONFIGS] = '{
		6'h00, 6'h01, 6'h02, 6'h04, 6'h05, 6'h06, 6'h08, 6'h09, 6'h0A,
		6'h10, 6'h11, 6'h12, 6'h14, 6'h15, 6'h16, 6'h18, 6'h19, 6'h1A,
		6'h20, 6'h21, 6'h22, 6'h24, 6'h25, 6'h26, 6'h28, 6'h29, 6'h2A
	};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_LOAD,
		ST_CHECK,
		ST_UPD,
		ST_FIN
	} cals_state_t;

	// controller to datapath
	typedef struct packed {
		logic                load_rule;
		logic                div_step;
		logic                row_we;
		logic [ROW_AW-1:0]   row_idx;
		logic                init_run;
		logic                mark;
		logic                rd_en;
		logic [CELL_CW-1:0]  rd_cell;
		logic                wr_en;
		logic [CELL_CW-1:0]  wr_cell;
		logic                commit;
		logic                finish;
	} cals_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic hit;
	} cals_sts_t;

endpackage

// ----- hdl/cals_ctrl.sv -----
// controller state machine for the lifetime search
module cals_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  cals_pkg::cals_sts_t  sts,
	output cals_pkg::cals_cmd_t  cmd
);
	import cals_pkg::*;

	cals_state_t            state_q, state_d;
	logic [CHUNK_CW-1:0]    chunk_q;
	logic [PASS_W-1:0]      pass_q;
	logic [CELL_CW-1:0]     cell_q;

	logic chunk_last, pass_last, cell_last;

	assign chunk_last = (chunk_q == CHUNK_CW'(NUM_CHUNKS - 1));
	assign pass_last  = (pass_q == PASS_W'(NUM_PASSES - 1));
	assign cell_last  = (cell_q == CELL_CW'(NUM_CELLS));

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// chunk, pass and cell counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_q <= '0;
			pass_q  <= '0;
			cell_q  <= '0;
		end else begin
			if (cmd.load_rule) begin
				chunk_q <= '0;
				pass_q  <= '0;
			end else if (cmd.div_step) begin
				if (chunk_last) begin
					chunk_q <= '0;
					pass_q  <= pass_q + PASS_W'(1);
				end else begin
					chunk_q <= chunk_q + CHUNK_CW'(1);
				end
			end
			if (cmd.mark) begin
				cell_q <= '0;
			end else if (state_q == ST_UPD) begin
				cell_q <= cell_q + CELL_CW'(1);
			end
		end
	end

	// next state and commands
	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		cmd.row_idx = pass_q;
		cmd.rd_cell = cell_q;
		cmd.wr_cell = cell_q - CELL_CW'(1);
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load_rule = 1'b1;
					state_d       = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (chunk_last) begin
					cmd.row_we = 1'b1;
					if (pass_last) begin
						state_d = ST_LOAD;
					end
				end
			end
			ST_LOAD: begin
				cmd.init_run = 1'b1;
				state_d      = ST_CHECK;
			end
			ST_CHECK: begin
				if (sts.hit) begin
					state_d = ST_FIN;
				end else begin
					cmd.mark = 1'b1;
					state_d  = ST_UPD;
				end
			end
			ST_UPD: begin
				cmd.rd_en  = !cell_last;
				cmd.wr_en  = (cell_q != '0);
				cmd.commit = cell_last;
				if (cell_last) begin
					state_d = ST_CHECK;
				end
			end
			ST_FIN: begin
				cmd.finish = 1'b1;
				state_d    = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);

	// the pass counter stays within 0..8 during extraction
	a_pass_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> pass_q < PASS_W'(NUM_PASSES))
		else $error("pass counter out of range");
	// every update round ends in a check
	a_upd_to_check: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> state_q == ST_CHECK)
		else $error("update round did not return to check");

endmodule

// ----- hdl/cals_dp.sv -----
// datapath: rule digit extraction, automaton stepping, visited map and results
module cals_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cals_pkg::cals_cmd_t           cmd,
	output cals_pkg::cals_sts_t           sts,
	input  logic [cals_pkg::RULE_W-1:0]   rule_number,
	input  logic                          cfg_we,
	input  logic [cals_pkg::THR_W-1:0]    cfg_wdata,
	output logic                          done,
	output logic [cals_pkg::LIFE_W-1:0]   lifetime,
	output logic                          meets_threshold,
	output logic                          new_longest,
	output logic [cals_pkg::RULE_W-1:0]   longest_rule
);
	import cals_pkg::*;

	logic [RULE_W-1:0]   rule_q;
	logic [WORK_W-1:0]   work_q;
	logic [REM_W-1:0]    rem_q;
	logic [ROW_W-1:0]    digit_mem [NUM_PASSES];
	logic [ROW_W-1:0]    row_s1;
	logic [TRIT_W-1:0]   col_s1;
	logic [TRIT_W-1:0]   cells_q [NUM_CELLS];
	logic [TRIT_W-1:0]   nxt_q [NUM_CELLS-1];
	logic [NUM_CONFIGS-1:0] visited_q;
	logic [LIFE_W-1:0]   count_q;
	logic [THR_W-1:0]    thr_q;
	logic [LIFE_W-1:0]   longest_life_q;
	logic [RULE_W-1:0]   longest_rule_q;
	logic                done_q;
	logic [LIFE_W-1:0]   lifetime_q;
	logic                meets_q;
	logic                longer_q;

	logic [REM_W-1:0]    rem_nxt;
	logic [CHUNK_W-1:0]  qbits;
	logic [ROW_AW-1:0]   rd_row;
	logic [TRIT_W-1:0]   c_up, c_dn;
	logic [TRIT_W-1:0]   new_trit;
	logic [CONF_W-1:0]   conf;
	logic                meets, longer;

	// one chunk of long division by 27, msb first
	always_comb begin
		logic [REM_W:0] tmp;
		rem_nxt = rem_q;
		qbits   = '0;
		for (int k = 0; k < CHUNK_W; k++) begin
			tmp = {rem_nxt, work_q[WORK_W-1-k]};
			if (tmp >= (REM_W+1)'(DIVISOR)) begin
				rem_nxt            = REM_W'(tmp - (REM_W+1)'(DIVISOR));
				qbits[CHUNK_W-1-k] = 1'b1;
			end else begin
				rem_nxt = tmp[REM_W-1:0];
			end
		end
	end

	// dividend shifts out, quotient shifts in
	always_ff @(posedge clk) begin
		if (cmd.load_rule) begin
			rule_q <= rule_number;
			work_q <= {{(WORK_W-RULE_W){1'b0}}, rule_number};
			rem_q  <= '0;
		end else if (cmd.div_step) begin
			work_q <= {work_q[WORK_W-CHUNK_W-1:0], qbits};
			rem_q  <= cmd.row_we ? '0 : rem_nxt;
		end
	end

	// neighbour selection for the cell being read
	always_comb begin
		unique case (cmd.rd_cell)
			2'd0: begin
				c_up = cells_q[1];
				c_dn = cells_q[2];
			end
			2'd1: begin
				c_up = cells_q[2];
				c_dn = cells_q[0];
			end
			2'd2: begin
				c_up = cells_q[0];
				c_dn = cells_q[1];
			end
			default: begin
				c_up = '0;
				c_dn = '0;
			end
		endcase
		rd_row = {2'b00, c_up} + {1'b0, c_dn, 1'b0} + {2'b00, c_dn};
	end

	// digit memory: one row per division pass, registered read
	always_ff @(posedge clk) begin
		if (cmd.row_we) begin
			digit_mem[cmd.row_idx] <= TRIT_LUT[rem_nxt];
		end
		if (cmd.rd_en) begin
			row_s1 <= digit_mem[rd_row];
			col_s1 <= cells_q[cmd.rd_cell];
		end
	end

	// pick the digit for the cell's own value
	always_comb begin
		unique case (col_s1)
			2'd0:    new_trit = row_s1[1:0];
			2'd1:    new_trit = row_s1[3:2];
			2'd2:    new_trit = row_s1[5:4];
			default: new_trit = '0;
		endcase
	end

	// cell registers: nxt_q holds cells 0 and 1, all three commit together
	always_ff @(posedge clk) begin
		if (cmd.init_run) begin
			cells_q[0] <= TRIT_W'(1);
			cells_q[1] <= '0;
			cells_q[2] <= '0;
		end else if (cmd.commit) begin
			cells_q[0] <= nxt_q[0];
			cells_q[1] <= nxt_q[1];
			cells_q[2] <= new_trit;
		end else if (cmd.wr_en) begin
			nxt_q[cmd.wr_cell[0]] <= new_trit;
		end
	end

	// configuration index and visited lookup
	assign conf    = CONF_W'(cells_q[0]) + CONF_W'(cells_q[1]) * CONF_W'(3)
		+ CONF_W'(cells_q[2]) * CONF_W'(9);
	assign sts.hit = visited_q[conf];

	// visited map and lifetime count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			visited_q <= '0;
			count_q   <= '0;
		end else if (cmd.init_run) begin
			visited_q <= '0;
			count_q   <= '0;
		end else if (cmd.mark) begin
			visited_q[conf] <= 1'b1;
			count_q         <= count_q + LIFE_W'(1);
		end
	end

	assign meets  = (count_q >= thr_q);
	assign longer = (count_q > longest_life_q);

	// threshold register, longest record and done flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q          <= '0;
			longest_life_q <= '0;
			longest_rule_q <= '0;
			done_q         <= 1'b0;
		end else begin
			if (cfg_we) begin
				thr_q <= cfg_wdata;
			end
			if (cmd.finish && longer) begin
				longest_life_q <= count_q;
				longest_rule_q <= rule_q;
			end
			done_q <= cmd.finish;
		end
	end

	// result register, loaded together with done, which is high for one cycle
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			lifetime_q <= count_q;
			meets_q    <= meets;
			longer_q   <= longer;
		end
	end

	assign done            = done_q;
	assign lifetime        = lifetime_q;
	assign meets_threshold = meets_q;
	assign new_longest     = longer_q;
	assign longest_rule    = longest_rule_q;

	// every transfer has seen at least the start configuration
	a_life_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> lifetime != '0)
		else $error("zero lifetime reported");
	// count tracks the number of marked configurations
	a_count_visited: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(visited_q) == int'(count_q))
		else $error("visited map and count disagree");
	// a new longest carries the rule just searched
	a_longest_rule: assert property (@(posedge clk) disable iff (!arst_n)
		done && new_longest |-> longest_rule == rule_q)
		else $error("new longest without its rule");
	// count never passes the number of configurations
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= LIFE_W'(NUM_CONFIGS))
		else $error("lifetime count overflow");

endmodule

// ----- hdl/cellular_automaton_lifetime_search_top.sv -----
// top level of the cellular automaton lifetime search
// sequence: from the start transfer, rule digit extraction (9 divide-by-27 passes, 8 bits a cycle),
//   then per automaton step a check, 3 digit memory reads and a commit, until a configuration
//   repeats; the lifetime L lies in 1..27.
// issue: one rule at a time; busy drops in the done cycle, so the next
//   start can be taken while the result is shown. done lasts one cycle, no stall.
// reset: arst_n clears the controller, visited map, longest record and threshold.
module cellular_automaton_lifetime_search_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [cals_pkg::RULE_W-1:0]   rule_number,
	input  logic                          cfg_we,
	input  logic [cals_pkg::THR_W-1:0]    cfg_wdata,
	output logic                          done,
	output logic [cals_pkg::LIFE_W-1:0]   lifetime,
	output logic                          meets_threshold,
	output logic                          new_longest,
	output logic [cals_pkg::RULE_W-1:0]   longest_rule
);
	import cals_pkg::*;

	cals_cmd_t cmd;
	cals_sts_t sts;

	// sequencing
	cals_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.cmd    (cmd)
	);

	// arithmetic, storage and results
	cals_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.rule_number     (rule_number),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.done            (done),
		.lifetime        (lifetime),
		.meets_threshold (meets_threshold),
		.new_longest     (new_longest),
		.longest_rule    (longest_rule)
	);

endmodule
